[design/mtt_pkg.sv]
package mtt_pkg;

    // Longest token, in stored characters
    localparam int MAX_TOKEN = 1024;
    localparam int LEN_W     = $clog2(MAX_TOKEN + 1);

    // Result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] ACC_MAX = 16'hFFFF;

    // Characters of interest
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_UPPER_E = 8'h45;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LOWER_E = 8'h65;

    typedef enum logic [2:0] {
        KIND_SEMICOLON     = 3'd0,
        KIND_COMMA         = 3'd1,
        KIND_FLOAT         = 3'd2,
        KIND_DOLLAR        = 3'd3,
        KIND_DOLLAR_SYMBOL = 3'd4,
        KIND_SYMBOL        = 3'd5,
        KIND_END           = 3'd6,
        KIND_MALFORMED     = 3'd7
    } token_kind_t;

    // Float literal recogniser states
    typedef enum logic [9:0] {
        FC_START = 10'b00_0000_0001,
        FC_MINUS = 10'b00_0000_0010,
        FC_INT   = 10'b00_0000_0100,
        FC_LDOT  = 10'b00_0000_1000,
        FC_DOT   = 10'b00_0001_0000,
        FC_FRAC  = 10'b00_0010_0000,
        FC_EXP   = 10'b00_0100_0000,
        FC_ESIGN = 10'b00_1000_0000,
        FC_EDIG  = 10'b01_0000_0000,
        FC_ERR   = 10'b10_0000_0000
    } float_state_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } text_item_t;

    typedef struct packed {
        token_kind_t token_kind;
        logic [10:0] token_length;
        logic [15:0] dollar_number;
        logic        end_of_text;
    } token_item_t;

    // Per-token scan state
    typedef struct packed {
        float_state_t     fc;
        logic             in_tok;
        logic             esc;
        logic             pwd;
        logic             ds;
        logic             pdf;
        logic [LEN_W-1:0] len;
        logic [15:0]      acc;
    } tok_state_t;

    localparam tok_state_t TOK_CLEAR = '{
        fc:     FC_START,
        in_tok: 1'b0,
        esc:    1'b0,
        pwd:    1'b0,
        ds:     1'b0,
        pdf:    1'b0,
        len:    '0,
        acc:    '0
    };

    // Results of one byte: up to two, in order
    typedef struct packed {
        logic [1:0]  count;
        token_item_t first;
        token_item_t second;
    } step_out_t;

endpackage

[design/mtt_lexer.sv]
module mtt_lexer
    import mtt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  text_item_t item,
    output step_out_t  step
);

    tok_state_t tok_reg;
    tok_state_t tok_next;
    logic       mal_reg;
    logic       mal_next;

    function automatic float_state_t next_float(float_state_t s, logic [7:0] b);
        logic d;
        logic dt;
        logic mi;
        logic pl;
        logic ex;
        float_state_t r;
        d  = (b >= CH_ZERO) && (b <= CH_NINE);
        dt = (b == CH_DOT);
        mi = (b == CH_MINUS);
        pl = (b == CH_PLUS);
        ex = (b == CH_LOWER_E) || (b == CH_UPPER_E);
        unique case (s)
            FC_START: r = mi ? FC_MINUS : d ? FC_INT : dt ? FC_LDOT : FC_ERR;
            FC_MINUS: r = d ? FC_INT : dt ? FC_LDOT : FC_ERR;
            FC_INT:   r = dt ? FC_DOT : ex ? FC_EXP : d ? FC_INT : FC_ERR;
            FC_LDOT:  r = d ? FC_FRAC : FC_ERR;
            FC_DOT:   r = d ? FC_FRAC : ex ? FC_EXP : FC_ERR;
            FC_FRAC:  r = ex ? FC_EXP : d ? FC_FRAC : FC_ERR;
            FC_EXP:   r = (pl || mi) ? FC_ESIGN : d ? FC_EDIG : FC_ERR;
            FC_ESIGN: r = d ? FC_EDIG : FC_ERR;
            FC_EDIG:  r = d ? FC_EDIG : FC_ERR;
            default:  r = FC_ERR;
        endcase
        return r;
    endfunction

    // Fold one byte into the token under way
    function automatic tok_state_t consume(tok_state_t s, logic [7:0] b);
        tok_state_t r;
        logic [19:0] v;
        logic        d;
        r     = s;
        d     = (b >= CH_ZERO) && (b <= CH_NINE);
        v     = 20'(s.acc) * 20'd10 + 20'(b[3:0]);
        r.fc  = next_float(s.fc, b);
        r.pwd = !s.esc && (b == CH_DOLLAR);
        r.esc = (b == CH_BSLASH) && !s.esc;
        // An escaping backslash is not stored
        if (!r.esc)
        begin
            if (s.len == '0)
            begin
                r.pdf = (b == CH_DOLLAR);
                r.acc = '0;
            end
            else if (s.pdf)
            begin
                if (d)
                    r.acc = (v > 20'(ACC_MAX)) ? ACC_MAX : v[15:0];
                else
                    r.pdf = 1'b0;
            end
            if (s.len < LEN_W'(MAX_TOKEN))
                r.len = s.len + LEN_W'(1);
        end
        return r;
    endfunction

    // Classify a finished token
    function automatic token_item_t emit(tok_state_t s);
        token_item_t r;
        r.token_length  = 11'(s.len);
        r.dollar_number = '0;
        r.end_of_text   = 1'b0;
        if (s.fc == FC_INT || s.fc == FC_DOT || s.fc == FC_FRAC || s.fc == FC_EDIG)
            r.token_kind = KIND_FLOAT;
        else if (s.ds && s.pdf && (s.len >= LEN_W'(2)))
        begin
            r.token_kind    = KIND_DOLLAR;
            r.dollar_number = s.acc;
        end
        else if (s.ds)
            r.token_kind = KIND_DOLLAR_SYMBOL;
        else
            r.token_kind = KIND_SYMBOL;
        return r;
    endfunction

    function automatic token_item_t bare(token_kind_t k);
        token_item_t r;
        r.token_kind    = k;
        r.token_length  = '0;
        r.dollar_number = '0;
        r.end_of_text   = 1'b0;
        return r;
    endfunction

    // Work out the results and next state of one byte
    always_comb
    begin
        logic        fin;
        logic        is_dig;
        logic        is_sp;
        logic        is_semi;
        logic        is_comma;
        logic        cut;
        logic        cont;
        logic        bc_v;
        tok_state_t  st_a;
        tok_state_t  start;
        tok_state_t  post;
        token_item_t a_item;
        token_item_t bc_item;

        fin      = item.final_byte;
        is_dig   = (item.text_byte >= CH_ZERO) && (item.text_byte <= CH_NINE);
        is_sp    = (item.text_byte == CH_SPACE) || (item.text_byte == CH_TAB) ||
                   (item.text_byte == CH_CR) || (item.text_byte == CH_LF);
        is_semi  = (item.text_byte == CH_SEMI);
        is_comma = (item.text_byte == CH_COMMA);

        st_a     = tok_reg;
        st_a.ds  = tok_reg.ds | (tok_reg.pwd & is_dig);
        st_a.pwd = 1'b0;

        cut  = tok_reg.in_tok &&
               !((tok_reg.len < LEN_W'(MAX_TOKEN)) &&
                 (tok_reg.esc || !(is_sp || is_semi || is_comma)));
        cont = tok_reg.in_tok && !cut;
        a_item = emit(st_a);

        start        = TOK_CLEAR;
        start.in_tok = 1'b1;

        bc_v    = 1'b0;
        bc_item = bare(KIND_SEMICOLON);
        if (cont)
            post = consume(st_a, item.text_byte);
        else if (is_sp)
            post = TOK_CLEAR;
        else if (is_semi)
        begin
            post = TOK_CLEAR;
            bc_v = 1'b1;
        end
        else if (is_comma)
        begin
            post    = TOK_CLEAR;
            bc_v    = 1'b1;
            bc_item = bare(KIND_COMMA);
        end
        else
            post = consume(start, item.text_byte);

        // Close the open token at the end of the text
        if (fin && post.in_tok)
        begin
            bc_v    = 1'b1;
            bc_item = emit(post);
        end

        step.first  = bare(KIND_END);
        step.second = bc_item;
        mal_next    = mal_reg | (item.text_byte == CH_NUL);

        if (mal_next)
        begin
            step.count             = {1'b0, fin};
            step.first             = bare(KIND_MALFORMED);
            step.first.end_of_text = 1'b1;
            tok_next               = TOK_CLEAR;
            mal_next               = !fin;
        end
        else
        begin
            if (cut)
            begin
                step.first = a_item;
                step.count = bc_v ? 2'd2 : 2'd1;
                if (fin && bc_v)
                    step.second.end_of_text = 1'b1;
                else if (fin)
                    step.first.end_of_text = 1'b1;
            end
            else
            begin
                if (bc_v)
                    step.first = bc_item;
                step.count             = {1'b0, bc_v | fin};
                step.first.end_of_text = fin;
            end
            tok_next = fin ? TOK_CLEAR : post;
        end
    end

    // Hold the scan state between bytes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= TOK_CLEAR;
            mal_reg <= 1'b0;
        end
        else if (accept)
        begin
            tok_reg <= tok_next;
            mal_reg <= mal_next;
        end
    end

endmodule

[design/mtt_outq.sv]
module mtt_outq
    import mtt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  step_out_t   push,
    input  logic        pop,
    output token_item_t head,
    output logic        not_empty,
    output logic        almost_full
);

    token_item_t      mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_inc;

    assign wr_ptr_inc  = wr_ptr_reg + PTR_W'(1);
    assign head        = mem_reg[rd_ptr_reg];
    assign not_empty   = (count_reg != '0);
    // Leave room for two results of the next byte
    assign almost_full = (count_reg > CNT_W'(QUEUE_DEPTH - 2));

    // Write up to two results
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem_reg[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            mem_reg[wr_ptr_inc] <= push.second;
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push.count);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            count_reg <= count_reg + CNT_W'(push.count) - CNT_W'(pop);
        end
    end

endmodule

[design/message_text_tokenizer.sv]
// A result enters the result queue at the clock edge that transfers its byte and is offered
// once the results ahead of it are taken. Throughput: one byte per cycle; a byte may yield
// two results, both queued, and the four-entry result queue stalls input above two entries.
// Reset: rst_n, asynchronous and active low, clears the token scan state, the
// malformed flag and the result queue.
module message_text_tokenizer
    import mtt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  text_item_t  item,
    output logic        token_valid,
    input  logic        token_stall,
    output token_item_t token
);

    logic      item_take;
    logic      token_take;
    logic      queue_full;
    step_out_t step;
    step_out_t push;

    assign item_stall = queue_full;
    assign item_take  = item_valid && !item_stall;
    assign token_take = token_valid && !token_stall;

    // Drop the results of a byte not transferred
    always_comb
    begin
        push = step;
        if (!item_take)
            push.count = 2'd0;
    end

    mtt_lexer u_lexer (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (item_take),
        .item   (item),
        .step   (step)
    );

    mtt_outq u_outq (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .pop         (token_take),
        .head        (token),
        .not_empty   (token_valid),
        .almost_full (queue_full)
    );

endmodule
